// File: hw/rtl/feedback_delay_line_assert.svh
// ============================================================================
// feedback_delay_line_assert.svh
// Assertion macros used by the feedback delay line checker.
// ============================================================================
`ifndef FEEDBACK_DELAY_LINE_ASSERT_SVH
`define FEEDBACK_DELAY_LINE_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define FDL_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define FDL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/fdl_pkg.sv
// ============================================================================
// fdl_pkg
// Constants, types and register codes of the feedback delay line.
// ============================================================================
package fdl_pkg;

    // The buffer depth must be a power of two.
    localparam int DEPTH       = 262144;
    localparam int ADDR_BITS   = $clog2(DEPTH);
    localparam int SAMPLE_BITS = 16;

    localparam int DELAY_BITS     = 18;
    localparam int GAIN_BITS      = 7;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 18;

    localparam logic [CFG_INDEX_BITS-1:0] REG_DELAY    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FEEDBACK = 2'd1;

    localparam logic [DELAY_BITS-1:0] DELAY_RESET = 18'd48000;
    localparam logic [GAIN_BITS-1:0]  GAIN_RESET  = 7'd50;

    // |delayed| * gain stays below 2^(SAMPLE_BITS+6) for a 7-bit gain.
    localparam int MAG_BITS = SAMPLE_BITS + 6;
    // Exact floor division by GAIN_DIV through a reciprocal: the rounding error of
    // RECIP times GAIN_DIV stays below 2^(SCALE_K-MAG_BITS).
    localparam int GAIN_DIV   = 100;
    localparam int SCALE_K    = MAG_BITS + 7;
    localparam int RECIP_BITS = SCALE_K - 6;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SCALE_K) + 64'(GAIN_DIV) - 64'd1) / 64'(GAIN_DIV);
    localparam logic [RECIP_BITS-1:0] RECIP = RECIP_FULL[RECIP_BITS-1:0];
    localparam int Q_BITS = SAMPLE_BITS;

    localparam int SUM_BITS = SAMPLE_BITS + 2;
    localparam logic signed [SUM_BITS-1:0] SUM_MAX =
        SUM_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [SUM_BITS-1:0] SUM_MIN = -SUM_MAX - SUM_BITS'(1);

    typedef struct packed {
        logic                          en;
        logic [ADDR_BITS-1:0]          addr;
        logic signed [SAMPLE_BITS-1:0] data;
    } wr_req_t;

    typedef struct packed {
        logic load_mag;
        logic load_q;
    } scale_ctl_t;

endpackage

// File: hw/rtl/fdl_store.sv
// ============================================================================
// fdl_store
// Sample buffer with one registered read port, one write port and a clearing
// sweep that zeroes every entry after reset.
// ============================================================================
module fdl_store (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  rd_en,
    input  logic [fdl_pkg::ADDR_BITS-1:0]         rd_addr,
    output logic signed [fdl_pkg::SAMPLE_BITS-1:0] rd_data,
    input  fdl_pkg::wr_req_t                      wr,
    output logic                                  clear_done
);

    logic signed [fdl_pkg::SAMPLE_BITS-1:0] mem [fdl_pkg::DEPTH];
    logic signed [fdl_pkg::SAMPLE_BITS-1:0] rd_data_reg;

    // The top bit of the sweep counter marks the end of the clearing pass.
    logic [fdl_pkg::ADDR_BITS:0] clr_reg;
    logic [fdl_pkg::ADDR_BITS:0] clr_next;

    logic                                   wen;
    logic [fdl_pkg::ADDR_BITS-1:0]          waddr;
    logic signed [fdl_pkg::SAMPLE_BITS-1:0] wdata;

    assign clear_done = clr_reg[fdl_pkg::ADDR_BITS];
    assign clr_next   = clr_reg + {{fdl_pkg::ADDR_BITS{1'b0}}, 1'b1};

    always_comb
    begin
        if (!clear_done)
        begin
            wen   = 1'b1;
            waddr = clr_reg[fdl_pkg::ADDR_BITS-1:0];
            wdata = '0;
        end
        else
        begin
            wen   = wr.en;
            waddr = wr.addr;
            wdata = wr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (!clear_done)
        begin
            clr_reg <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/fdl_scale.sv
// ============================================================================
// fdl_scale
// Two-stage gain unit: magnitude of delayed sample times gain, then an exact
// divide by one hundred through a reciprocal multiply. Sign travels alongside.
// ============================================================================
module fdl_scale (
    input  logic                                   clk,
    input  fdl_pkg::scale_ctl_t                    ctl,
    input  logic signed [fdl_pkg::SAMPLE_BITS-1:0] delayed,
    input  logic [fdl_pkg::GAIN_BITS-1:0]          gain,
    output logic [fdl_pkg::Q_BITS-1:0]             q_mag,
    output logic                                   q_neg
);

    localparam int AbsBits  = fdl_pkg::SAMPLE_BITS + 1;
    localparam int ProdBits = AbsBits + fdl_pkg::GAIN_BITS;
    localparam int RcpBits  = fdl_pkg::MAG_BITS + fdl_pkg::RECIP_BITS;

    logic [AbsBits-1:0]              ext_d;
    logic [AbsBits-1:0]              abs_d;
    logic [ProdBits-1:0]             prod_a;
    logic [fdl_pkg::MAG_BITS-1:0]    mag_next;
    logic [fdl_pkg::MAG_BITS-1:0]    mag_reg;
    logic                            neg_a_reg;
    logic [RcpBits-1:0]              prod_b;
    logic [fdl_pkg::Q_BITS-1:0]      q_next;
    logic [fdl_pkg::Q_BITS-1:0]      q_reg;
    logic                            neg_b_reg;

    always_comb
    begin
        ext_d    = {delayed[fdl_pkg::SAMPLE_BITS-1], delayed};
        abs_d    = delayed[fdl_pkg::SAMPLE_BITS-1] ? (~ext_d + AbsBits'(1)) : ext_d;
        prod_a   = abs_d * {{AbsBits{1'b0}}, gain};
        mag_next = prod_a[fdl_pkg::MAG_BITS-1:0];
    end

    always_comb
    begin
        prod_b = {{fdl_pkg::RECIP_BITS{1'b0}}, mag_reg}
               * {{fdl_pkg::MAG_BITS{1'b0}}, fdl_pkg::RECIP};
        q_next = prod_b[fdl_pkg::SCALE_K +: fdl_pkg::Q_BITS];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_mag)
        begin
            mag_reg   <= mag_next;
            neg_a_reg <= delayed[fdl_pkg::SAMPLE_BITS-1];
        end
        if (ctl.load_q)
        begin
            q_reg     <= q_next;
            neg_b_reg <= neg_a_reg;
        end
    end

    assign q_mag = q_reg;
    assign q_neg = neg_b_reg;

endmodule

// File: hw/rtl/feedback_delay_line.sv
// ============================================================================
// feedback_delay_line
// Pipeline: an accepted input request passes the buffer read, magnitude,
// quotient and output registers to a valid result. Throughput: one sample per
// cycle while the delay is three samples or more and the output does not stall.
// Delays of 0, 1 and 2 wait on a buffer write still in the pipeline, which holds
// off the next sample. Reset: a clearing pass zeroes the 262144-entry buffer,
// with input held off meanwhile; configuration writes are taken throughout.
// ============================================================================
module feedback_delay_line (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [fdl_pkg::SAMPLE_BITS-1:0] sample_in,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [fdl_pkg::SAMPLE_BITS-1:0] sample_out,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [fdl_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [fdl_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

    localparam int AW = fdl_pkg::ADDR_BITS;
    localparam int SB = fdl_pkg::SAMPLE_BITS;

    logic [fdl_pkg::DELAY_BITS-1:0] delay_reg;
    logic [fdl_pkg::GAIN_BITS-1:0]  gain_reg;

    logic [AW-1:0] wp_reg;
    logic [AW-1:0] wp_next;

    logic [fdl_pkg::DELAY_BITS+AW-1:0] delay_ext;
    logic [AW-1:0]                     delay_mod;
    logic [AW-1:0]                     rd_addr;

    // Stage valid bits and carried payload.
    logic v1_reg, v2_reg, v3_reg, ov_reg;
    logic signed [SB-1:0] x1_reg, x2_reg, x3_reg, y_reg;
    logic [AW-1:0]        wa1_reg, wa2_reg, wa3_reg;

    logic out_take, adv1, adv2, adv3, r1, r2, r3;
    logic hazard, clear_done, accept;

    logic signed [SB-1:0]                  rd_data;
    logic [fdl_pkg::Q_BITS-1:0]            q_mag;
    logic                                  q_neg;
    logic signed [fdl_pkg::SUM_BITS-1:0]   x_ext, q_ext, sum;
    logic signed [SB-1:0]                  y_next;

    fdl_pkg::wr_req_t    wr;
    fdl_pkg::scale_ctl_t sctl;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg <= fdl_pkg::DELAY_RESET;
            gain_reg  <= fdl_pkg::GAIN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                fdl_pkg::REG_DELAY:
                begin
                    delay_reg <= cfg_data[fdl_pkg::DELAY_BITS-1:0];
                end
                fdl_pkg::REG_FEEDBACK:
                begin
                    gain_reg <= cfg_data[fdl_pkg::GAIN_BITS-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // The delay is reduced modulo the depth, then the tap trails the old pointer.
    always_comb
    begin
        delay_ext = {{AW{1'b0}}, delay_reg};
        delay_mod = delay_ext[AW-1:0];
        rd_addr   = wp_reg - delay_mod;
        wp_next   = wp_reg + AW'(1);
    end

    // A request may not read a slot that an item still in flight will write.
    assign hazard = (v1_reg && (wa1_reg == rd_addr))
                 || (v2_reg && (wa2_reg == rd_addr))
                 || (v3_reg && (wa3_reg == rd_addr));

    always_comb
    begin
        out_take = !ov_reg || out_ready;
        adv3     = v3_reg && out_take;
        r3       = !v3_reg || out_take;
        adv2     = v2_reg && r3;
        r2       = !v2_reg || r3;
        adv1     = v1_reg && r2;
        r1       = !v1_reg || r2;
        in_ready = r1 && clear_done && !hazard;
        accept   = in_valid && in_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                wp_reg <= wp_next;
            end
            v1_reg <= accept || (v1_reg && !adv1);
            v2_reg <= adv1 || (v2_reg && !adv2);
            v3_reg <= adv2 || (v3_reg && !adv3);
            ov_reg <= adv3 || (ov_reg && !out_ready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x1_reg  <= sample_in;
            wa1_reg <= wp_next;
        end
        if (adv1)
        begin
            x2_reg  <= x1_reg;
            wa2_reg <= wa1_reg;
        end
        if (adv2)
        begin
            x3_reg  <= x2_reg;
            wa3_reg <= wa2_reg;
        end
        if (adv3)
        begin
            y_reg <= y_next;
        end
    end

    fdl_store u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_en      (accept),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .wr         (wr),
        .clear_done (clear_done)
    );

    assign sctl.load_mag = adv1;
    assign sctl.load_q   = adv2;

    fdl_scale u_scale (
        .clk     (clk),
        .ctl     (sctl),
        .delayed (rd_data),
        .gain    (gain_reg),
        .q_mag   (q_mag),
        .q_neg   (q_neg)
    );

    always_comb
    begin
        x_ext = {{(fdl_pkg::SUM_BITS - SB){x3_reg[SB-1]}}, x3_reg};
        q_ext = {{(fdl_pkg::SUM_BITS - fdl_pkg::Q_BITS){1'b0}}, q_mag};
        sum   = q_neg ? (x_ext - q_ext) : (x_ext + q_ext);
        if (sum > fdl_pkg::SUM_MAX)
        begin
            y_next = fdl_pkg::SUM_MAX[SB-1:0];
        end
        else if (sum < fdl_pkg::SUM_MIN)
        begin
            y_next = fdl_pkg::SUM_MIN[SB-1:0];
        end
        else
        begin
            y_next = sum[SB-1:0];
        end
    end

    // The result goes back into the buffer as it moves to the output register.
    assign wr.en   = adv3;
    assign wr.addr = wa3_reg;
    assign wr.data = y_next;

    assign out_valid  = ov_reg;
    assign sample_out = y_reg;

endmodule

// File: hw/rtl/fdl_checker.sv
// ============================================================================
// fdl_checker
// Port-level checks of the feedback delay line, bound to the top level.
// ============================================================================
`include "feedback_delay_line_assert.svh"

module fdl_checker (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   in_valid,
    input logic                                   in_ready,
    input logic                                   out_valid,
    input logic                                   out_ready,
    input logic signed [fdl_pkg::SAMPLE_BITS-1:0] sample_out,
    input logic                                   cfg_valid,
    input logic                                   cfg_ready,
    input logic [fdl_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input logic [fdl_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

    logic [2:0]                     inflight_reg;
    logic [2:0]                     inflight_next;
    logic [fdl_pkg::DELAY_BITS-1:0] delay_reg;
    logic                           in_acc, out_acc, out_stall, zero_delay;

    assign in_acc     = in_valid && in_ready;
    assign out_acc    = out_valid && out_ready;
    assign out_stall  = out_valid && !out_ready;
    assign zero_delay = (delay_reg == '0);

    always_comb
    begin
        inflight_next = inflight_reg;
        if (in_acc && !out_acc)
        begin
            inflight_next = inflight_reg + 3'd1;
        end
        else if (out_acc && !in_acc)
        begin
            inflight_next = inflight_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
            delay_reg    <= fdl_pkg::DELAY_RESET;
        end
        else
        begin
            inflight_reg <= inflight_next;
            if (cfg_valid && cfg_ready && (cfg_index == fdl_pkg::REG_DELAY))
            begin
                delay_reg <= cfg_data[fdl_pkg::DELAY_BITS-1:0];
            end
        end
    end

    `FDL_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(sample_out), "result not held")
    `FDL_ASSERT_IMP(a_no_phantom, out_acc, inflight_reg != 3'd0, "result without a request")
    `FDL_ASSERT_IMP(a_inflight_cap, 1'b1, inflight_reg <= 3'd4, "too many requests in flight")
    `FDL_ASSERT_NEXT(a_zero_delay_gap, in_acc && zero_delay, !in_acc, "zero delay not stalled")

endmodule

bind feedback_delay_line fdl_checker u_fdl_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
);

// File: test/feedback_delay_line_tb.sv
// ============================================================================
// feedback_delay_line_tb
// Self-checking testbench for the feedback delay line. A queue-fed driver
// offers samples and a monitor tracks an internal model of the circular
// buffer. The monitor predicts each output when its input request is taken
// and checks results in order. Feedback gain and delay are reprogrammed
// between phases. Random idling on both sides, and one long output stall,
// exercise the handshakes.
// ============================================================================
`timescale 1ns / 100ps

module feedback_delay_line_tb;

    localparam int SAMPLE_BITS    = fdl_pkg::SAMPLE_BITS;
    localparam int DEPTH          = fdl_pkg::DEPTH;
    localparam int ADDR_BITS      = fdl_pkg::ADDR_BITS;
    localparam int DELAY_BITS     = fdl_pkg::DELAY_BITS;
    localparam int GAIN_BITS      = fdl_pkg::GAIN_BITS;
    localparam int CFG_INDEX_BITS = fdl_pkg::CFG_INDEX_BITS;
    localparam int CFG_DATA_BITS  = fdl_pkg::CFG_DATA_BITS;

    localparam int CYCLE_LIMIT = 1200000;
    localparam int HOLD_CYCLES = 500;
    localparam int TAIL_CYCLES = 8;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          in_valid  = 1'b0;
    logic                          in_ready;
    logic signed [SAMPLE_BITS-1:0] sample_in = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [CFG_INDEX_BITS-1:0]     cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]      cfg_data  = '0;

    // Model of the block: circular sample buffer, write pointer and registers.
    bit signed [SAMPLE_BITS-1:0]   echo_mem [DEPTH];
    logic [ADDR_BITS-1:0]          wr_ptr    = '0;
    logic [DELAY_BITS-1:0]         delay_reg = fdl_pkg::DELAY_RESET;
    logic [GAIN_BITS-1:0]          gain_reg  = fdl_pkg::GAIN_RESET;

    logic signed [SAMPLE_BITS-1:0] queued_inputs [$];
    logic signed [SAMPLE_BITS-1:0] due_outputs [$];
    logic signed [SAMPLE_BITS-1:0] want_sample;

    int issued_count  = 0;
    int checked_count = 0;
    int error_count   = 0;
    int cycle_count   = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_left     = 0;
    logic hold_req    = 1'b0;

    feedback_delay_line dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    // Advances the buffer model by one sample and returns the expected output.
    function automatic logic signed [SAMPLE_BITS-1:0] echo_predict(
        input logic signed [SAMPLE_BITS-1:0] x);
        logic [ADDR_BITS-1:0]          rd_addr;
        int                            delayed;
        int                            gain;
        int                            total;
        logic signed [SAMPLE_BITS-1:0] y;
        rd_addr = wr_ptr - ADDR_BITS'(delay_reg);
        delayed = echo_mem[rd_addr];
        gain    = gain_reg;
        // Division of signed ints truncates toward zero.
        total   = x + (delayed * gain) / 100;
        if (total > 32767)
            y = 16'sh7FFF;
        else if (total < -32768)
            y = 16'sh8000;
        else
            y = SAMPLE_BITS'(total);
        wr_ptr = wr_ptr + 1'b1;
        echo_mem[wr_ptr] = y;
        return y;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
        case ($urandom_range(9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return SAMPLE_BITS'(int'($urandom_range(64)) - 32);
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    task automatic push_sample(input logic signed [SAMPLE_BITS-1:0] s);
        queued_inputs.push_back(s);
        issued_count++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input int unsigned delay_len, input int unsigned gain_pct);
        write_reg(fdl_pkg::REG_DELAY, CFG_DATA_BITS'(delay_len));
        write_reg(fdl_pkg::REG_FEEDBACK, CFG_DATA_BITS'(gain_pct));
    endtask

    // Waits until every issued sample has come back, then lets the pipeline settle.
    task automatic drain();
        while (checked_count != issued_count)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // Input driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            sample_in <= '0;
        end
        else if (!in_valid || in_ready)
        begin
            if (queued_inputs.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid  <= 1'b1;
                sample_in <= queued_inputs.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Long output stall, counted down on its own.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_req)
            hold_left <= HOLD_CYCLES;
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // Monitor: tracks register writes, predicts on input requests, checks outputs.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    fdl_pkg::REG_DELAY:    delay_reg = cfg_data[DELAY_BITS-1:0];
                    fdl_pkg::REG_FEEDBACK: gain_reg  = cfg_data[GAIN_BITS-1:0];
                    default:               ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (due_outputs.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected sample_out %0d", sample_out));
                end
                else
                begin
                    want_sample = due_outputs.pop_front();
                    if (sample_out !== want_sample)
                        report_mismatch($sformatf("sample_out %0d, expected %0d",
                                                  sample_out, want_sample));
                    checked_count++;
                end
            end
            if (in_valid && in_ready)
                due_outputs.push_back(echo_predict(sample_in));
            out_ready <= !hold_req && hold_left == 0 && $urandom_range(99) >= stall_pct;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        int idle_send [4];
        int idle_recv [4];
        int unsigned dly;
        int unsigned gn;
        int count;
        idle_send = '{0, 46, 0, 20};
        idle_recv = '{0, 0, 46, 20};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: the buffer is clear, so each output equals its input.
        push_sample(16'sh7FFF); push_sample(16'sh8000); push_sample(16'sh0000);
        push_sample(16'shFFFF); push_sample(16'sh0001);
        drain();

        // Zero delay at maximum gain drives the sum into both limits.
        set_config(0, 127);
        push_sample(16'sh7FFF); push_sample(16'sh7FFF); push_sample(16'sh7FFF);
        push_sample(16'sh8000); push_sample(16'sh8000); push_sample(16'sh8000);
        drain();

        set_config(1, 100);
        push_sample(16'sd20000); push_sample(-16'sd20000); push_sample(16'sd1);
        push_sample(-16'sd1); push_sample(16'sd3);
        drain();

        set_config(2, 0);
        push_sample(16'sd1234); push_sample(-16'sd1234); push_sample(16'sd5);
        drain();

        // Largest delay: the read slot is the one about to be written.
        set_config(262143, 99);
        push_sample(16'sh7FFF); push_sample(16'sh8000); push_sample(16'sd100);
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0:       dly = 0;
                1:       dly = 1;
                2:       dly = 2;
                3:       dly = $urandom_range(24, 3);
                4:       dly = $urandom_range(4000, 25);
                5:       dly = 262143;
                6:       dly = $urandom_range(262143);
                default: dly = $urandom_range(8, 3);
            endcase
            gn = (ph == 0) ? 127 : (ph == 1) ? 100 : $urandom_range(127);
            set_config(dly, gn);
            send_idle_pct = idle_send[ph % 4];
            stall_pct     = idle_recv[ph % 4];
            count = $urandom_range(175, 155);
            for (int k = 0; k < count; k++)
                push_sample(random_sample());
            drain();
        end

        // Output held off while the driver keeps offering, so the input backs up.
        send_idle_pct = 0;
        stall_pct     = 0;
        set_config($urandom_range(12, 3), 75);
        hold_req <= 1'b1;
        for (int k = 0; k < 150; k++)
            push_sample(random_sample());
        @(posedge clk);
        hold_req <= 1'b0;
        drain();

        if (due_outputs.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", due_outputs.size()));
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/fdl_pkg.sv
hw/rtl/fdl_store.sv
hw/rtl/fdl_scale.sv
hw/rtl/feedback_delay_line.sv
hw/rtl/fdl_checker.sv
test/feedback_delay_line_tb.sv
